@@ hdl/integer_to_ascii_padded_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII converter checker.
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_PADDED_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_PADDED_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define I2A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define I2A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, constants and the glyph function shared by the converter modules.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Number of digit cells; enough for twenty decimal digits of a 64-bit value.
  localparam int DEPTH = 20;
  // Upper bound on the requested field width.
  localparam int MAX_OUT = 64;
  // Bits shifted through the cell row per conversion.
  localparam int VALUE_W = 64;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hex;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_PAD,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // Upper case hexadecimal glyph for one digit.
  function automatic logic [6:0] glyph(input logic [3:0] d);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {3'b000, d};
    end else begin
      ch = 7'h37 + {3'b000, d};
    end
    return ch;
  endfunction

endpackage

@@ hdl/i2a_cell.sv @@
// ----------------------------------------------------------------------------
// i2a_cell
// One digit cell: holds a 4-bit digit, runs a shift-and-add-3 step or a
// plain hex shift, and can take its lower neighbor's digit.
// ----------------------------------------------------------------------------
module i2a_cell (
  input  logic                clk,
  input  i2a_pkg::chain_ctrl_t ctrl,
  input  logic                bit_in,
  input  logic [3:0]          digit_in,
  output logic [3:0]          digit,
  output logic                carry_out
);
  import i2a_pkg::*;

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // A decimal digit of five or more is corrected before it doubles.
  always_comb begin
    if (!ctrl.hex && (digit_r >= 4'd5)) begin
      adj = digit_r + 4'd3;
    end else begin
      adj = digit_r;
    end
  end

  always_comb begin
    case (ctrl.op)
      CELL_CLEAR:  digit_nxt = 4'd0;
      CELL_DABBLE: digit_nxt = {adj[2:0], bit_in};
      CELL_SHIFT:  digit_nxt = digit_in;
      default:     digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit     = digit_r;
  assign carry_out = adj[3];

endmodule

@@ hdl/i2a_chain.sv @@
// ----------------------------------------------------------------------------
// i2a_chain
// The row of digit cells. Bits enter at the least significant cell and
// digits leave from the most significant one.
// ----------------------------------------------------------------------------
module i2a_chain (
  input  logic                clk,
  input  i2a_pkg::chain_ctrl_t ctrl,
  input  logic                bit_in,
  output logic [3:0]          top_digit
);
  import i2a_pkg::*;

  logic [3:0] digits [DEPTH];
  logic       carry  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       cell_bit;
    logic [3:0] cell_din;
    if (i == 0) begin : g_first
      assign cell_bit = bit_in;
      assign cell_din = 4'd0;
    end else begin : g_rest
      assign cell_bit = carry[i-1];
      assign cell_din = digits[i-1];
    end
    i2a_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (cell_bit),
      .digit_in  (cell_din),
      .digit     (digits[i]),
      .carry_out (carry[i])
    );
  end

  assign top_digit = digits[DEPTH-1];

endmodule

@@ hdl/integer_to_ascii_padded_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_padded_top
// Converts a 64-bit integer to padded ASCII text, one character per word.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                             | Direction
//  --------+---------------------------------------------------+----------
//  input   | in_valid, in_stall, in_value, in_is_signed,       | in
//          | in_base_hex, in_pad_width, in_zero_pad            |
//  result  | out_valid, out_stall, out_character, out_last     | out
//
// One number is worked on at a time. After acceptance the cell row shifts the
// 64-bit magnitude in bit by bit, drops leading zero digits (L digits remain)
// and sets up padding, then emits P pad words, an optional sign word and L
// digit words. The input side stays closed from acceptance until the last
// digit word enters the output register.
// Reset (rst_n low, synchronous) returns the controller to idle and empties
// the output register. Stalls on the result side hold the output word and
// the pad, sign and digit states; conversion and normalization run on.
//
module integer_to_ascii_padded_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  input  logic        in_is_signed,
  input  logic        in_base_hex,
  input  logic [6:0]  in_pad_width,
  input  logic        in_zero_pad,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_character,
  output logic        out_last
);
  import i2a_pkg::*;

  state_t            state_r, state_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [5:0]        bitcnt_r, bitcnt_nxt;
  logic [4:0]        dcnt_r, dcnt_nxt;
  logic [6:0]        pad_r, pad_nxt;
  logic [6:0]        width_r, width_nxt;
  logic              neg_r, neg_nxt;
  logic              hex_r, hex_nxt;
  logic              zpad_r, zpad_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  chain_ctrl_t       ctrl;
  logic [3:0]        top_digit;
  logic              accept;
  logic              adv;
  logic [6:0]        len;

  // The digit row. Its most significant cell is the one that is printed.
  i2a_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (val_r[VALUE_W-1]),
    .top_digit (top_digit)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // The output register can take a new word when it is empty or being taken.
  assign adv      = !out_valid_r || !out_stall;
  // Printed length without padding: digits plus the sign.
  assign len      = {2'b00, dcnt_r} + {6'd0, neg_r};

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    bitcnt_nxt    = bitcnt_r;
    dcnt_nxt      = dcnt_r;
    pad_nxt       = pad_r;
    width_nxt     = width_r;
    neg_nxt       = neg_r;
    hex_nxt       = hex_r;
    zpad_nxt      = zpad_r;
    out_valid_nxt = adv ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl.op       = CELL_HOLD;
    ctrl.hex      = hex_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Negative signed values are converted as their magnitude, which
          // also covers the most negative value exactly.
          if (in_is_signed && in_value[VALUE_W-1]) begin
            val_nxt = ~in_value + 64'd1;
            neg_nxt = 1'b1;
          end else begin
            val_nxt = in_value;
            neg_nxt = 1'b0;
          end
          hex_nxt    = !in_is_signed && in_base_hex;
          zpad_nxt   = in_zero_pad;
          width_nxt  = (in_pad_width > 7'(MAX_OUT)) ? 7'(MAX_OUT) : in_pad_width;
          bitcnt_nxt = 6'd0;
          ctrl.op    = CELL_CLEAR;
          state_nxt  = ST_CONV;
        end
      end

      ST_CONV: begin
        // One magnitude bit enters the row per cycle, most significant first.
        ctrl.op    = CELL_DABBLE;
        val_nxt    = {val_r[VALUE_W-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 6'd1;
        if (bitcnt_r == 6'(VALUE_W - 1)) begin
          dcnt_nxt  = 5'(DEPTH);
          state_nxt = ST_NORM;
        end
      end

      ST_NORM: begin
        // Leading zero digits are shifted out; a lone zero digit stays.
        if ((top_digit == 4'd0) && (dcnt_r > 5'd1)) begin
          ctrl.op  = CELL_SHIFT;
          dcnt_nxt = dcnt_r - 5'd1;
        end else begin
          pad_nxt   = (width_r > len) ? (width_r - len) : 7'd0;
          state_nxt = ST_PAD;
        end
      end

      ST_PAD: begin
        if (pad_r == 7'd0) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end else if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = zpad_r ? CH_ZERO : CH_SPACE;
          out_last_nxt  = 1'b0;
          pad_nxt       = pad_r - 7'd1;
        end
      end

      ST_SIGN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGITS;
        end
      end

      ST_DIGITS: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = glyph(top_digit);
          out_last_nxt  = (dcnt_r == 5'd1);
          ctrl.op       = CELL_SHIFT;
          dcnt_nxt      = dcnt_r - 5'd1;
          if (dcnt_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bitcnt_r    <= 6'd0;
      dcnt_r      <= 5'd0;
      pad_r       <= 7'd0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bitcnt_r    <= bitcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      pad_r       <= pad_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    width_r    <= width_nxt;
    hex_r      <= hex_nxt;
    zpad_r     <= zpad_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

@@ hdl/i2a_checker.sv @@
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks for the integer to ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_padded_top_assert.svh"

module i2a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_character,
  input logic        out_last
);

  // A stalled result word holds its contents.
  `I2A_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_character) && $stable(out_last),
    "stalled result word changed")

  // An accepted number keeps the input side closed on the next cycle.
  `I2A_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
    "input open right after an accepted word")

  // The input side reopens only as the final character is presented.
  `I2A_ASSERT_IMP(a_reopen_on_last, $fell(in_stall), out_valid && out_last,
    "input reopened without a final character")

  // The final character of a number is always a digit.
  `I2A_ASSERT_IMP(a_last_is_digit, out_valid && out_last,
    ((out_character >= 7'h30) && (out_character <= 7'h39)) ||
    ((out_character >= 7'h41) && (out_character <= 7'h46)),
    "final character is not a digit")

endmodule

bind integer_to_ascii_padded_top i2a_checker u_i2a_checker (.*);
